// ===== src/chte_pkg.sv =====
// chte_pkg: shared types and constants of the cuckoo hash table engine
// depends on nothing
`timescale 1ns / 1ps
package chte_pkg;
   localparam logic [31:0] SEED_FIRST  = 32'hdeadbeaf;
   localparam logic [31:0] SEED_SECOND = 32'h00c0ffee;
   localparam int KEY_W   = 64;
   localparam int VALUE_W = 32;

   typedef enum logic [1:0] {
      CMD_PUT    = 2'd0,
      CMD_GET    = 2'd1,
      CMD_REMOVE = 2'd2,
      CMD_NOP    = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_MISS     = 2'd1,
      ST_OVERFLOW = 2'd2
   } status_type;

   localparam logic CSR_TABLE_POWER = 1'b0;
   localparam logic CSR_KICK_LIMIT  = 1'b1;

   typedef enum logic [3:0] {
      S_IDLE, S_HASH, S_RD1, S_RD1W, S_RD2, S_RD2W, S_DECIDE,
      S_KHASH, S_KRD, S_KRDW, S_KWRITE, S_DONE
   } state_type;

   // hash unit handshake
   typedef struct packed {
      logic start;
      logic busy;
      logic done;
   } hash_ctl_type;

   function automatic logic [31:0] rotl32(input logic [31:0] x, input logic [4:0] r);
      logic [63:0] d;
      d = {x, x} << r;
      return d[63:32];
   endfunction
endpackage

// ===== src/cuckoo_hash_table_engine_core.sv =====
// cuckoo_hash_table_engine_core: two-choice cuckoo hash table top level
// depends on chte_pkg, chte_hash, chte_store
`timescale 1ns / 1ps
// one word at a time: a get, remove or put without kicks hashes the key in the shared mix unit,
// reads both buckets, decides and writes, then loads the output register
// each kick rehashes the displaced entry, reads its destination bucket, then writes it back
// a nop goes straight to the output load; a held response only delays the following answer
// synchronous reset, then the valid bits are cleared one bucket per cycle (1024 buckets by
// default) with req_tready low; registers reset to table_power 10, kick_limit 16
module cuckoo_hash_table_engine_core #(
   parameter int LOG2_BUCKETS = 10,
   parameter int KEY_BYTES = 8,
   parameter int VALUE_BITS = 32
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [103:0] req_tdata,   // cmd[1:0], key[65:2], value[97:66], zero pad
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [135:0] rsp_tdata,   // status[1:0], read_value, dropped_key, dropped_value
   input  logic         csr_wr_en,
   input  logic [0:0]   csr_index,
   input  logic [7:0]   csr_wdata
);
   import chte_pkg::*;

   localparam int AW = LOG2_BUCKETS;

   state_type state_ff, state_in;
   logic [3:0]  tpow_ff;
   logic [7:0]  klim_ff;
   logic [1:0]  cmd_ff, cmd_in;
   logic [63:0] key_ff, key_in;          // key of the original request
   logic [VALUE_BITS-1:0] val_ff, val_in;
   logic [63:0] ck_ff, ck_in;            // entry being relocated
   logic [VALUE_BITS-1:0] cv_ff, cv_in;
   logic [AW-1:0] h1_ff, h1_in, h2_ff, h2_in, from_ff, from_in, dest_ff, dest_in;
   logic        hit1_ff, hit1_in, vld1_ff, vld1_in;
   logic [VALUE_BITS-1:0] v1_ff, v1_in;
   logic [7:0]  tries_ff, tries_in;
   logic [1:0]  st_ff, st_in;
   logic [31:0] rv_ff, rv_in;
   logic [63:0] dk_ff, dk_in;
   logic [31:0] dv_ff, dv_in;
   logic        ovalid_ff, ovalid_in;
   logic [135:0] rdata_ff, rdata_in;     // response word held for the result side

   // mask to the number of buckets in use
   logic [3:0]  pow_sat;
   logic [AW-1:0] mask;
   always_comb begin
      pow_sat = tpow_ff;
      if (pow_sat < 4'd2) pow_sat = 4'd2;
      if (32'(pow_sat) > AW) pow_sat = 4'(AW);
      mask = AW'((32'd1 << pow_sat) - 32'd1);
   end

   logic [63:0] kmask;
   assign kmask = (KEY_BYTES == 8) ? 64'hffff_ffff_ffff_ffff :
                  ((64'd1 << (8*KEY_BYTES)) - 64'd1);

   // hash unit
   logic        h_start, h_done;
   logic [63:0] h_key;
   logic [31:0] hc, hb;
   chte_hash #(.KEY_BYTES(KEY_BYTES)) u_hash (
      .clock(clock), .reset(reset), .start(h_start), .key(h_key),
      .done(h_done), .hash_c(hc), .hash_b(hb)
   );

   // bucket store
   logic [AW-1:0] rd_addr, wr_addr;
   logic          rd_valid, wr_en, clr_en, store_ready;
   logic [63:0]   rd_key, wr_key;
   logic [VALUE_BITS-1:0] rd_value, wr_value;
   chte_store #(.LOG2_BUCKETS(AW), .VALUE_BITS(VALUE_BITS)) u_store (
      .clock(clock), .reset(reset), .rd_addr(rd_addr), .rd_valid(rd_valid),
      .rd_key(rd_key), .rd_value(rd_value), .wr_en(wr_en), .wr_addr(wr_addr),
      .wr_key(wr_key), .wr_value(wr_value), .clr_en(clr_en), .ready(store_ready)
   );

   logic hit_now;
   assign hit_now = rd_valid && (rd_key == key_ff);

   logic [AW-1:0] ha, hbm;
   assign ha  = hc[AW-1:0] & mask;
   assign hbm = hb[AW-1:0] & mask;

   always_comb begin
      state_in = state_ff;
      cmd_in = cmd_ff; key_in = key_ff; val_in = val_ff;
      ck_in = ck_ff; cv_in = cv_ff;
      h1_in = h1_ff; h2_in = h2_ff; from_in = from_ff; dest_in = dest_ff;
      hit1_in = hit1_ff; vld1_in = vld1_ff; v1_in = v1_ff;
      tries_in = tries_ff;
      st_in = st_ff; rv_in = rv_ff; dk_in = dk_ff; dv_in = dv_ff;
      ovalid_in = ovalid_ff;
      rdata_in = rdata_ff;
      h_start = 1'b0; h_key = key_ff;
      rd_addr = h1_ff; wr_en = 1'b0; clr_en = 1'b0;
      wr_addr = h1_ff; wr_key = key_ff; wr_value = val_ff;
      req_tready = 1'b0;

      if (ovalid_ff && rsp_tready) ovalid_in = 1'b0;

      unique case (state_ff)
         // no word is taken until the valid bits are cleared
         S_IDLE: if (store_ready) begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd_in = req_tdata[1:0];
               key_in = req_tdata[65:2] & kmask;
               val_in = req_tdata[66 +: VALUE_BITS];
               st_in = ST_OK; rv_in = '0; dk_in = '0; dv_in = '0;
               if (cmd_type'(req_tdata[1:0]) == CMD_NOP) state_in = S_DONE;
               else begin
                  h_start = 1'b1;
                  h_key = req_tdata[65:2] & kmask;
                  state_in = S_HASH;
               end
            end
         end
         S_HASH: if (h_done) begin
            h1_in = ha; h2_in = hbm;
            state_in = S_RD1;
         end
         S_RD1: begin rd_addr = h1_ff; state_in = S_RD1W; end
         S_RD1W: begin
            hit1_in = hit_now; vld1_in = rd_valid; v1_in = rd_value;
            rd_addr = h2_ff;
            state_in = S_RD2W;
         end
         S_RD2: state_in = S_RD2W;
         S_RD2W: begin
            state_in = S_DONE;
            unique case (cmd_type'(cmd_ff))
               CMD_GET: begin
                  if (hit1_ff) rv_in = 32'(v1_ff);
                  else if (hit_now) rv_in = 32'(rd_value);
                  else st_in = ST_MISS;
               end
               CMD_REMOVE: begin
                  if (hit1_ff) begin clr_en = 1'b1; wr_addr = h1_ff; end
                  else if (hit_now) begin clr_en = 1'b1; wr_addr = h2_ff; end
                  else st_in = ST_MISS;
               end
               default: begin
                  wr_en = 1'b1;
                  if (hit1_ff) wr_addr = h1_ff;
                  else if (hit_now) wr_addr = h2_ff;
                  else if (!vld1_ff) wr_addr = h1_ff;
                  else if (!rd_valid) wr_addr = h2_ff;
                  else begin
                     wr_addr = h2_ff;
                     ck_in = rd_key; cv_in = rd_value;
                     from_in = h2_ff; tries_in = 8'd1;
                     h_start = 1'b1; h_key = rd_key;
                     state_in = S_KHASH;
                  end
               end
            endcase
         end
         S_DECIDE: state_in = S_DONE;
         S_KHASH: if (h_done) begin
            dest_in = (ha == from_ff) ? hbm : ha;
            state_in = S_KRD;
         end
         S_KRD: begin rd_addr = dest_ff; state_in = S_KRDW; end
         S_KRDW: begin
            // read-modify-write of the destination bucket
            wr_en = 1'b1; wr_addr = dest_ff; wr_key = ck_ff; wr_value = cv_ff;
            if (!rd_valid) state_in = S_DONE;
            else begin
               ck_in = rd_key; cv_in = rd_value;
               if (tries_ff < klim_ff) begin
                  from_in = dest_ff;
                  tries_in = tries_ff + 8'd1;
                  h_start = 1'b1; h_key = rd_key;
                  state_in = S_KHASH;
               end else begin
                  st_in = ST_OVERFLOW;
                  dk_in = rd_key; dv_in = 32'(rd_value);
                  state_in = S_DONE;
               end
            end
         end
         S_KWRITE: state_in = S_DONE;
         // load the output register once the previous word has gone
         S_DONE: if (!ovalid_ff || rsp_tready) begin
            ovalid_in = 1'b1;
            rdata_in = {6'd0, dv_ff, dk_ff, rv_ff, st_ff};
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ovalid_ff <= 1'b0;
         tpow_ff <= 4'd10;
         klim_ff <= 8'd16;
      end else begin
         state_ff <= state_in;
         ovalid_ff <= ovalid_in;
         if (csr_wr_en && csr_index == CSR_TABLE_POWER) tpow_ff <= csr_wdata[3:0];
         if (csr_wr_en && csr_index == CSR_KICK_LIMIT) klim_ff <= csr_wdata;
      end
      cmd_ff <= cmd_in; key_ff <= key_in; val_ff <= val_in;
      ck_ff <= ck_in; cv_ff <= cv_in;
      h1_ff <= h1_in; h2_ff <= h2_in; from_ff <= from_in; dest_ff <= dest_in;
      hit1_ff <= hit1_in; vld1_ff <= vld1_in; v1_ff <= v1_in;
      tries_ff <= tries_in;
      st_ff <= st_in; rv_ff <= rv_in; dk_ff <= dk_in; dv_ff <= dv_in;
      rdata_ff <= rdata_in;
   end

   assign rsp_tvalid = ovalid_ff;
   assign rsp_tdata  = rdata_ff;
endmodule

// ===== src/chte_hash.sv =====
// chte_hash: iterative lookup3 final mix, one mix step per cycle
// depends on chte_pkg
`timescale 1ns / 1ps
module chte_hash #(
   parameter int KEY_BYTES = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [63:0]           key,
   output logic                  done,
   output logic [31:0]           hash_c,
   output logic [31:0]           hash_b
);
   import chte_pkg::*;

   localparam logic [31:0] INIT = 32'hdeadbeef + 32'(KEY_BYTES) + SEED_FIRST;

   logic [31:0] a_ff, b_ff, c_ff, a_in, b_in, c_in;
   logic [2:0]  step_ff, step_in;
   logic        busy_ff, busy_in;
   logic [31:0] ka, kb;

   always_comb begin
      ka = 32'd0;
      kb = 32'd0;
      for (int i = 0; i < 8; i++) begin
         if (i < KEY_BYTES) begin
            if (i < 4) ka[8*i +: 8] = key[8*i +: 8];
            else       kb[8*(i-4) +: 8] = key[8*i +: 8];
         end
      end
   end

   always_comb begin
      a_in = a_ff; b_in = b_ff; c_in = c_ff;
      step_in = step_ff; busy_in = busy_ff;
      done = 1'b0;
      if (start) begin
         a_in = INIT + ka;
         b_in = INIT + kb;
         c_in = INIT + SEED_SECOND;
         step_in = 3'd0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // one mix line per cycle through one xor and subtract
         case (step_ff)
            3'd0: c_in = (c_ff ^ b_ff) - rotl32(b_ff, 5'd14);
            3'd1: a_in = (a_ff ^ c_ff) - rotl32(c_ff, 5'd11);
            3'd2: b_in = (b_ff ^ a_ff) - rotl32(a_ff, 5'd25);
            3'd3: c_in = (c_ff ^ b_ff) - rotl32(b_ff, 5'd16);
            3'd4: a_in = (a_ff ^ c_ff) - rotl32(c_ff, 5'd4);
            3'd5: b_in = (b_ff ^ a_ff) - rotl32(a_ff, 5'd14);
            3'd6: c_in = (c_ff ^ b_ff) - rotl32(b_ff, 5'd24);
            default: begin
               busy_in = 1'b0;
               done = 1'b1;
            end
         endcase
         step_in = step_ff + 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= 3'd0;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
      end
      a_ff <= a_in; b_ff <= b_in; c_ff <= c_in;
   end

   assign hash_c = c_ff;
   assign hash_b = b_ff;
endmodule

// ===== src/chte_store.sv =====
// chte_store: bucket memory for keys and data plus per-bucket valid bits
// depends on chte_pkg
`timescale 1ns / 1ps
module chte_store #(
   parameter int LOG2_BUCKETS = 10,
   parameter int VALUE_BITS = 32
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic [LOG2_BUCKETS-1:0] rd_addr,
   output logic                    rd_valid,
   output logic [63:0]             rd_key,
   output logic [VALUE_BITS-1:0]   rd_value,
   input  logic                    wr_en,
   input  logic [LOG2_BUCKETS-1:0] wr_addr,
   input  logic [63:0]             wr_key,
   input  logic [VALUE_BITS-1:0]   wr_value,
   input  logic                    clr_en,
   output logic                    ready
);
   import chte_pkg::*;

   localparam int DEPTH = 1 << LOG2_BUCKETS;

   logic [63:0]             key_mem [DEPTH];
   logic [VALUE_BITS-1:0]   val_mem [DEPTH];
   logic                    vld_mem [DEPTH];
   logic [63:0]             rk_ff;
   logic [VALUE_BITS-1:0]   rv_ff;
   logic                    rvld_ff;
   logic                    clearing_ff;
   logic [LOG2_BUCKETS-1:0] clr_addr_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         key_mem[wr_addr] <= wr_key;
         val_mem[wr_addr] <= wr_value;
      end
      rk_ff <= key_mem[rd_addr];
      rv_ff <= val_mem[rd_addr];
   end

   // valid bits: one write a cycle, cleared bucket by bucket after reset
   always_ff @(posedge clock) begin
      if (clearing_ff) vld_mem[clr_addr_ff] <= 1'b0;
      else if (wr_en) vld_mem[wr_addr] <= 1'b1;
      else if (clr_en) vld_mem[wr_addr] <= 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff <= 1'b1;
         clr_addr_ff <= '0;
         rvld_ff     <= 1'b0;
      end else begin
         if (clearing_ff) begin
            if (clr_addr_ff == '1) clearing_ff <= 1'b0;
            clr_addr_ff <= clr_addr_ff + 1'b1;
         end
         rvld_ff <= vld_mem[rd_addr];
      end
   end

   assign rd_valid = rvld_ff;
   assign rd_key   = rk_ff;
   assign rd_value = rv_ff;
   assign ready    = !clearing_ff;
endmodule
